[hdl/sadsr_pkg.sv]
// Shared types, codes and constants of the sawtooth/ADSR note sequencer.
package sadsr_pkg;

	localparam int SONG_DEPTH_DEF = 16;

	localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
	localparam logic [1:0] FUNC_ENVELOPE = 2'd1;
	localparam logic [1:0] FUNC_WRITE    = 2'd2;

	localparam logic [15:0] PHASE_LIMIT = 16'd32768;
	localparam logic [15:0] END_PITCH   = 16'hFFFF;
	localparam logic [15:0] PITCH_RESET = 16'd231;

	// Step numerator of the attack; decay and release use half of it.
	localparam int ATTACK_NUM = 256;
	localparam int DIV_STEPS  = 9;

	typedef struct packed {
		logic [15:0] pitch;
		logic [15:0] attack;
		logic [15:0] decay;
		logic [15:0] sustain;
		logic [15:0] rel;
	} song_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMP_ADD,
		ST_SAMP_MUL,
		ST_WRITE,
		ST_ENV,
		ST_LOAD,
		ST_DIV_A_GO,
		ST_DIV_A_WAIT,
		ST_DIV_D_GO,
		ST_DIV_D_WAIT,
		ST_DIV_R_GO,
		ST_DIV_R_WAIT,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DIV_ATTACK,
		DIV_DECAY,
		DIV_RELEASE
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     phase_upd;
		logic     level_upd;
		logic     mem_wr;
		logic     env_upd;
		logic     load;
		logic     div_start;
		logic     div_store;
		div_sel_t div_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic ended;
		logic rem_le1;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/sadsr_div.sv]
// Restoring divider: fixed numerator 256 over a 16-bit divisor, one quotient bit a cycle.
module sadsr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [8:0]  quotient
);
	import sadsr_pkg::*;

	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [8:0]  num_q;
	logic [8:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, num_q[8]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			num_q <= 9'(ATTACK_NUM);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			num_q <= {num_q[7:0], 1'b0};
			quo_q <= {quo_q[7:0], fits};
		end
	end

	// divide by zero gives a zero step
	assign quotient = (den_q == 16'd0) ? 9'd0 : quo_q;
	assign done     = done_q;

endmodule

[hdl/sadsr_dp.sv]
// Datapath: phase accumulator, envelope, song table, step divider and result register.
module sadsr_dp #(
	parameter int SONG_DEPTH = sadsr_pkg::SONG_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sadsr_pkg::ctrl_cmd_t  cmd,
	output sadsr_pkg::dp_status_t status,
	input  logic [3:0]            entry_index,
	input  logic [15:0]           pitch_step,
	input  logic [15:0]           attack_len,
	input  logic [15:0]           decay_len,
	input  logic [15:0]           sustain_len,
	input  logic [15:0]           release_len,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [7:0]            level,
	output logic                  note_active,
	output logic                  song_ended
);
	import sadsr_pkg::*;

	localparam int POS_W = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;

	// captured transaction
	logic [3:0]  item_idx_q;
	song_entry_t item_q;

	// tone and envelope state
	logic [15:0] phase_q;
	logic [7:0]  amp_q;
	logic [7:0]  rem_q;
	logic [15:0] pitch_q;
	logic [7:0]  att_step_q;
	logic [7:0]  dec_step_q;
	logic [7:0]  rel_step_q;
	logic [15:0] cur_attack_q;
	logic [15:0] cur_decay_q;
	logic [15:0] cur_release_q;
	logic [16:0] cur_ad_q;
	logic [17:0] cur_ads_q;
	logic [POS_W-1:0] pos_q;
	logic        ended_q;
	logic [7:0]  level_q;

	// song table
	logic [79:0] mem [SONG_DEPTH];
	logic [79:0] rd_q;
	song_entry_t rd_entry;
	logic        idx_ok;

	// result register
	logic        out_valid_q;
	logic [7:0]  out_level_q;
	logic        out_active_q;
	logic        out_ended_q;

	logic [15:0] phase_sum;
	logic [15:0] prod;
	logic        rem_nz;
	logic        lt_a, gt_a, lt_ad, gt_ads;
	logic [15:0] div_den;
	logic        div_done;
	logic [8:0]  div_quo;

	assign rd_entry = song_entry_t'(rd_q);
	assign rem_nz   = rem_q != 8'd0;
	assign idx_ok   = {5'd0, item_idx_q} < 9'(SONG_DEPTH);

	assign phase_sum = phase_q + pitch_q;
	assign prod      = 16'(phase_q[14:7]) * 16'(amp_q);

	assign lt_a   = {8'd0, rem_q} < cur_attack_q;
	assign gt_a   = {8'd0, rem_q} > cur_attack_q;
	assign lt_ad  = {9'd0, rem_q} < cur_ad_q;
	assign gt_ads = {10'd0, rem_q} > cur_ads_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_ATTACK:  div_den = cur_attack_q;
			DIV_DECAY:   div_den = cur_decay_q;
			DIV_RELEASE: div_den = cur_release_q;
			default:     div_den = cur_attack_q;
		endcase
	end

	sadsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_idx_q <= entry_index;
			item_q     <= '{pitch_step, attack_len, decay_len, sustain_len, release_len};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && idx_ok)
			mem[POS_W'(item_idx_q)] <= item_q;
		rd_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			amp_q         <= '0;
			rem_q         <= '0;
			pitch_q       <= PITCH_RESET;
			att_step_q    <= '0;
			dec_step_q    <= '0;
			rel_step_q    <= '0;
			cur_attack_q  <= '0;
			cur_decay_q   <= '0;
			cur_release_q <= '0;
			cur_ad_q      <= '0;
			cur_ads_q     <= '0;
			pos_q         <= '0;
			ended_q       <= 1'b0;
			level_q       <= '0;
		end else begin
			if (cmd.phase_upd && rem_nz)
				phase_q <= (phase_sum > PHASE_LIMIT) ? 16'd0 : phase_sum;
			if (cmd.level_upd)
				level_q <= rem_nz ? prod[15:8] : 8'd0;
			if (cmd.env_upd && rem_nz) begin
				// attack, decay and release windows never overlap
				if (lt_a)
					amp_q <= amp_q + att_step_q;
				else if (gt_a && lt_ad)
					amp_q <= amp_q - dec_step_q;
				else if (gt_ads)
					amp_q <= amp_q - rel_step_q;
				rem_q <= rem_q - 8'd1;
			end
			if (cmd.load) begin
				if (rd_entry.pitch == END_PITCH)
					ended_q <= 1'b1;
				rem_q         <= rd_entry.attack[7:0] + rd_entry.decay[7:0]
				                 + rd_entry.sustain[7:0] + rd_entry.rel[7:0];
				amp_q         <= '0;
				pitch_q       <= rd_entry.pitch;
				cur_attack_q  <= rd_entry.attack;
				cur_decay_q   <= rd_entry.decay;
				cur_release_q <= rd_entry.rel;
				cur_ad_q      <= {1'b0, rd_entry.attack} + {1'b0, rd_entry.decay};
				cur_ads_q     <= {2'b0, rd_entry.attack} + {2'b0, rd_entry.decay}
				                 + {2'b0, rd_entry.sustain};
				pos_q         <= (pos_q == POS_W'(SONG_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
			end
			if (cmd.div_store) begin
				case (cmd.div_sel)
					DIV_ATTACK:  att_step_q <= div_quo[7:0];
					DIV_DECAY:   dec_step_q <= div_quo[8:1];
					DIV_RELEASE: rel_step_q <= div_quo[8:1];
					default:     att_step_q <= div_quo[7:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level_q  <= level_q;
			out_active_q <= rem_nz;
			out_ended_q  <= ended_q;
		end
	end

	assign status.ended    = ended_q;
	assign status.rem_le1  = rem_q <= 8'd1;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign level       = out_level_q;
	assign note_active = out_active_q;
	assign song_ended  = out_ended_q;

endmodule

[hdl/sadsr_ctrl.sv]
// Controller state machine sequencing the datapath for each transaction.
module sadsr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            func,
	input  sadsr_pkg::dp_status_t status,
	output sadsr_pkg::ctrl_cmd_t  cmd,
	output logic                  in_stall
);
	import sadsr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_SAMPLE:   state_d = ST_SAMP_ADD;
						FUNC_ENVELOPE: state_d = status.ended ? ST_DONE : ST_ENV;
						FUNC_WRITE:    state_d = ST_WRITE;
						default:       state_d = ST_DONE;
					endcase
				end
			end
			ST_SAMP_ADD:   state_d = ST_SAMP_MUL;
			ST_SAMP_MUL:   state_d = ST_DONE;
			ST_WRITE:      state_d = ST_DONE;
			ST_ENV:        state_d = status.rem_le1 ? ST_LOAD : ST_DONE;
			ST_LOAD:       state_d = ST_DIV_A_GO;
			ST_DIV_A_GO:   state_d = ST_DIV_A_WAIT;
			ST_DIV_A_WAIT: if (status.div_done) state_d = ST_DIV_D_GO;
			ST_DIV_D_GO:   state_d = ST_DIV_D_WAIT;
			ST_DIV_D_WAIT: if (status.div_done) state_d = ST_DIV_R_GO;
			ST_DIV_R_GO:   state_d = ST_DIV_R_WAIT;
			ST_DIV_R_WAIT: if (status.div_done) state_d = ST_DONE;
			ST_DONE:       if (status.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SAMP_ADD: cmd.phase_upd = 1'b1;
			ST_SAMP_MUL: cmd.level_upd = 1'b1;
			ST_WRITE:    cmd.mem_wr    = 1'b1;
			ST_ENV:      cmd.env_upd   = 1'b1;
			ST_LOAD:     cmd.load      = 1'b1;
			ST_DIV_A_GO: begin
				cmd.div_sel   = DIV_ATTACK;
				cmd.div_start = 1'b1;
			end
			ST_DIV_A_WAIT: begin
				cmd.div_sel   = DIV_ATTACK;
				cmd.div_store = status.div_done;
			end
			ST_DIV_D_GO: begin
				cmd.div_sel   = DIV_DECAY;
				cmd.div_start = 1'b1;
			end
			ST_DIV_D_WAIT: begin
				cmd.div_sel   = DIV_DECAY;
				cmd.div_store = status.div_done;
			end
			ST_DIV_R_GO: begin
				cmd.div_sel   = DIV_RELEASE;
				cmd.div_start = 1'b1;
			end
			ST_DIV_R_WAIT: begin
				cmd.div_sel   = DIV_RELEASE;
				cmd.div_store = status.div_done;
			end
			ST_DONE:     cmd.out_load = status.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

[hdl/sawtooth_adsr_note_sequencer.sv]
// Top level of the sawtooth tone generator with ADSR envelope and song table.
//
// One transaction in gives exactly one result transaction out, showing the state after it.
// func selects the work: a sample tick advances the sawtooth phase by the current
// pitch (clearing it above 32768) and produces level = top byte of
// (phase[14:7] * amplitude), or 0 when no note is active; an envelope tick steps
// the amplitude through attack/decay/release and counts the note down, loading
// the next song table entry when the count reaches zero; a write stores one
// entry of the song table (slots at or beyond SONG_DEPTH are ignored). An entry
// with pitch 65535 ends the song; envelope ticks are then ignored. The song table
// is not cleared at reset: every slot the song reaches must be written first.
// Timing: one transaction at a time, input stalled until the result is handed to
// the output register. Writes store the entry, unknown codes and envelope ticks after
// the end of the song go straight to the result, sample ticks do the phase add, then
// the 8x8 multiply, and other envelope ticks step the envelope; a tick that loads a
// note also works out the three envelope steps in turn on one shared restoring divider at
// 9 quotient bits each. A stalled output holds the transaction until the output register
// is free; a result waiting there does not stop the next transaction being accepted.
module sawtooth_adsr_note_sequencer #(
	parameter int SONG_DEPTH = sadsr_pkg::SONG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  entry_index,
	input  logic [15:0] pitch_step,
	input  logic [15:0] attack_len,
	input  logic [15:0] decay_len,
	input  logic [15:0] sustain_len,
	input  logic [15:0] release_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  level,
	output logic        note_active,
	output logic        song_ended
);
	import sadsr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencing: one state per datapath step
	sadsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// tone state, envelope, song table and output register
	sadsr_dp #(
		.SONG_DEPTH (SONG_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (entry_index),
		.pitch_step  (pitch_step),
		.attack_len  (attack_len),
		.decay_len   (decay_len),
		.sustain_len (sustain_len),
		.release_len (release_len),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.level       (level),
		.note_active (note_active),
		.song_ended  (song_ended)
	);

endmodule
